// File: hdl/piks_pkg.sv
// piks_pkg: shared types, character codes and the reserved-word table
// of the identifier and keyword scanner. No dependencies.
`timescale 1ns / 1ps

package piks_pkg;

  localparam int BUF_DEPTH   = 8;
  localparam int WORD_COUNT  = 43;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  localparam logic [3:0] OP_AND  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_MOD  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd7;
  localparam logic [3:0] OP_IN   = 4'd14;
  localparam logic [3:0] OP_NONE = 4'd15;

  localparam logic [5:0] SYM_IDENT = 6'd0,  SYM_DO = 6'd6,      SYM_TO = 6'd7;
  localparam logic [5:0] SYM_DOWNTO = 6'd8, SYM_END = 6'd9,     SYM_UNTIL = 6'd10;
  localparam logic [5:0] SYM_OF = 6'd11,    SYM_THEN = 6'd12,   SYM_ELSE = 6'd13;
  localparam logic [5:0] SYM_BEGIN = 6'd19, SYM_IF = 6'd20,     SYM_CASE = 6'd21;
  localparam logic [5:0] SYM_REPEAT = 6'd22, SYM_WHILE = 6'd23, SYM_FOR = 6'd24;
  localparam logic [5:0] SYM_WITH = 6'd25,  SYM_GOTO = 6'd26,   SYM_LABEL = 6'd27;
  localparam logic [5:0] SYM_CONST = 6'd28, SYM_TYPE = 6'd29,   SYM_VAR = 6'd30;
  localparam logic [5:0] SYM_PROC = 6'd31,  SYM_FUNC = 6'd32,   SYM_PROGRAM = 6'd33;
  localparam logic [5:0] SYM_FORWARD = 6'd34, SYM_NOT = 6'd38,  SYM_MULOP = 6'd39;
  localparam logic [5:0] SYM_ADDOP = 6'd40, SYM_RELOP = 6'd41,  SYM_SET = 6'd42;
  localparam logic [5:0] SYM_PACKED = 6'd43, SYM_ARRAY = 6'd44, SYM_RECORD = 6'd45;
  localparam logic [5:0] SYM_FILE = 6'd46,  SYM_OTHERWISE = 6'd47, SYM_USES = 6'd49;
  localparam logic [5:0] SYM_UNIT = 6'd50,  SYM_INTERFACE = 6'd51, SYM_IMPL = 6'd52;
  localparam logic [5:0] SYM_EXTERNAL = 6'd53, SYM_SEPARATE = 6'd54;

  typedef struct packed {
    logic [63:0] name;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic [5:0]  sym;
    logic [3:0]  opr;
    logic [63:0] name;
    logic [15:0] length;
  } result_t;

  typedef struct packed {
    logic [5:0] sym;
    logic [3:0] opr;
  } match_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } queue_head_t;

  typedef struct packed {
    logic [63:0] word;
    logic [5:0]  sym;
    logic [3:0]  opr;
  } word_entry_t;

  localparam word_entry_t WORDS [WORD_COUNT] = '{
    '{"DO      ", SYM_DO, OP_NONE},       '{"WITH    ", SYM_WITH, OP_NONE},
    '{"IN      ", SYM_RELOP, OP_IN},      '{"TO      ", SYM_TO, OP_NONE},
    '{"GOTO    ", SYM_GOTO, OP_NONE},     '{"SET     ", SYM_SET, OP_NONE},
    '{"DOWNTO  ", SYM_DOWNTO, OP_NONE},   '{"LABEL   ", SYM_LABEL, OP_NONE},
    '{"PACKED  ", SYM_PACKED, OP_NONE},   '{"END     ", SYM_END, OP_NONE},
    '{"CONST   ", SYM_CONST, OP_NONE},    '{"ARRAY   ", SYM_ARRAY, OP_NONE},
    '{"UNTIL   ", SYM_UNTIL, OP_NONE},    '{"TYPE    ", SYM_TYPE, OP_NONE},
    '{"RECORD  ", SYM_RECORD, OP_NONE},   '{"OF      ", SYM_OF, OP_NONE},
    '{"VAR     ", SYM_VAR, OP_NONE},      '{"FILE    ", SYM_FILE, OP_NONE},
    '{"THEN    ", SYM_THEN, OP_NONE},     '{"PROCEDUR", SYM_PROC, OP_NONE},
    '{"USES    ", SYM_USES, OP_NONE},     '{"ELSE    ", SYM_ELSE, OP_NONE},
    '{"FUNCTION", SYM_FUNC, OP_NONE},     '{"UNIT    ", SYM_UNIT, OP_NONE},
    '{"BEGIN   ", SYM_BEGIN, OP_NONE},    '{"PROGRAM ", SYM_PROGRAM, OP_NONE},
    '{"INTERFAC", SYM_INTERFACE, OP_NONE}, '{"IF      ", SYM_IF, OP_NONE},
    '{"SEGMENT ", SYM_PROGRAM, OP_NONE},  '{"IMPLEMEN", SYM_IMPL, OP_NONE},
    '{"CASE    ", SYM_CASE, OP_NONE},     '{"FORWARD ", SYM_FORWARD, OP_NONE},
    '{"EXTERNAL", SYM_EXTERNAL, OP_NONE}, '{"REPEAT  ", SYM_REPEAT, OP_NONE},
    '{"NOT     ", SYM_NOT, OP_NONE},      '{"OTHERWIS", SYM_OTHERWISE, OP_NONE},
    '{"WHILE   ", SYM_WHILE, OP_NONE},    '{"AND     ", SYM_MULOP, OP_AND},
    '{"DIV     ", SYM_MULOP, OP_DIV},     '{"MOD     ", SYM_MULOP, OP_MOD},
    '{"FOR     ", SYM_FOR, OP_NONE},      '{"OR      ", SYM_ADDOP, OP_OR},
    '{"SEPARATE", SYM_SEPARATE, OP_NONE}
  };

  // parallel compare against every table word, first hit wins
  function automatic match_t lookup(input logic [63:0] name);
    match_t m;
    logic   found;
    m.sym = SYM_IDENT;
    m.opr = OP_NONE;
    found = 1'b0;
    for (int k = 0; k < WORD_COUNT; k++) begin
      if (!found && WORDS[k].word == name) begin
        m.sym = WORDS[k].sym;
        m.opr = WORDS[k].opr;
        found = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// File: hdl/piks_front.sv
// piks_front: classifies source bytes, collects the upper-cased name and the
// scan length, and hands a finished name to the queue. Uses piks_pkg.
`timescale 1ns / 1ps

module piks_front #(
  parameter int NAME_LEN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           source_byte,
  output logic                 q_push,
  output piks_pkg::entry_t     q_data
);

  localparam int IDX_W = $clog2(piks_pkg::BUF_DEPTH);

  logic [7:0]  name_buffer [piks_pkg::BUF_DEPTH];
  logic [3:0]  kept_count;
  logic [15:0] scanned_count;

  logic       is_upper, is_lower, is_digit, is_under, is_name;
  logic [7:0] upper_byte;
  logic       keep;

  assign is_upper = (source_byte >= 8'h41) && (source_byte <= 8'h5A);
  assign is_lower = (source_byte >= 8'h61) && (source_byte <= 8'h7A);
  assign is_digit = (source_byte >= 8'h30) && (source_byte <= 8'h39);
  assign is_under = (source_byte == piks_pkg::CHAR_UNDERSCORE);
  assign is_name  = is_upper || is_lower || is_digit || is_under;
  assign upper_byte = is_lower ? (source_byte & 8'hDF) : source_byte;
  assign keep = !is_under && (kept_count < 4'(NAME_LEN));

  always_comb begin
    for (int i = 0; i < piks_pkg::BUF_DEPTH; i++) begin
      q_data.name[63 - 8*i -: 8] = name_buffer[i];
    end
    q_data.length = scanned_count;
  end

  assign q_push = accept && !is_name;

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      for (int i = 0; i < piks_pkg::BUF_DEPTH; i++) begin
        name_buffer[i] <= piks_pkg::CHAR_SPACE;
      end
      kept_count    <= '0;
      scanned_count <= '0;
    end else if (accept) begin
      if (scanned_count != 16'hFFFF) begin
        scanned_count <= scanned_count + 16'd1;
      end
      if (keep) begin
        name_buffer[kept_count[IDX_W-1:0]] <= upper_byte;
        kept_count <= kept_count + 4'd1;
      end
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (kept_count == 4'd0) && (scanned_count == 16'd0))
    else $error("front state not cleared after a terminating byte");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    accept && is_name |=> kept_count <= 4'(NAME_LEN))
    else $error("kept count ran past the name length");

endmodule

// File: hdl/piks_queue.sv
// piks_queue: short queue of finished names between the front and the
// keyword lookup. Uses piks_pkg.
`timescale 1ns / 1ps

module piks_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  piks_pkg::entry_t       wr_data,
  input  logic                   pop,
  output piks_pkg::queue_head_t  head,
  output logic                   full
);

  localparam int PTR_W = (piks_pkg::QUEUE_DEPTH > 1) ? $clog2(piks_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(piks_pkg::QUEUE_DEPTH + 1);

  piks_pkg::entry_t mem [piks_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(piks_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(piks_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(piks_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("name queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("name queue read while empty");

endmodule

// File: hdl/piks_back.sv
// piks_back: takes names off the queue, looks them up in the reserved-word
// table and holds the result for the consumer. Uses piks_pkg.
`timescale 1ns / 1ps

module piks_back (
  input  logic                   clk,
  input  logic                   rst,
  input  piks_pkg::queue_head_t  head,
  output logic                   take,
  input  logic                   pop,
  output logic                   out_valid,
  output piks_pkg::result_t      result
);

  piks_pkg::match_t m;

  assign m    = piks_pkg::lookup(head.data.name);
  // the result register refills in the same cycle it is drained
  assign take = head.valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (take) begin
      result.sym    <= m.sym;
      result.opr    <= m.opr;
      result.name   <= head.data.name;
      result.length <= head.data.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_refill: assert property (@(posedge clk) disable iff (rst)
    head.valid && !out_valid |=> out_valid)
    else $error("waiting name not moved into the result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result register valid after reset");

endmodule

// File: hdl/pascal_identifier_keyword_scanner.sv
// pascal_identifier_keyword_scanner: top level, front collector, name queue
// and keyword lookup stage. Uses piks_pkg, piks_front, piks_queue, piks_back.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+------------------
//   input    | source_byte[7:0]                              | push / full
//   result   | symbol_code, operator_code, name_chars,       | empty / pop
//            | scan_length                                   |
//
// one source byte accepted every cycle while full is low; full is high only
// while the name queue holds two names not yet looked up and the byte would
// have to wait. a terminating byte is written into the name queue, then moved
// into the result register once it is free, where it shows (empty low); lookup
// is parallel table compares on the queue head in the back stage.
// a stalled consumer fills the result register, then the two-entry queue.
// rst is synchronous: buffer to spaces, counts to zero, queue and result empty.
`timescale 1ns / 1ps

module pascal_identifier_keyword_scanner #(
  parameter int NAME_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  symbol_code,
  output logic [3:0]  operator_code,
  output logic [63:0] name_chars,
  output logic [15:0] scan_length
);

  logic                  accept;
  logic                  q_push;
  piks_pkg::entry_t      q_data;
  piks_pkg::queue_head_t q_head;
  logic                  q_pop;
  logic                  out_valid;
  piks_pkg::result_t     result;

  assign accept = push && !full;

  piks_front #(.NAME_LEN(NAME_LEN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .source_byte (source_byte),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  piks_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_data),
    .pop     (q_pop),
    .head    (q_head),
    .full    (full)
  );

  piks_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .take      (q_pop),
    .pop       (pop && out_valid),
    .out_valid (out_valid),
    .result    (result)
  );

  assign empty         = !out_valid;
  assign symbol_code   = result.sym;
  assign operator_code = result.opr;
  assign name_chars    = result.name;
  assign scan_length   = result.length;

endmodule
